// ----- src/fblb_pkg.sv -----
package fblb_pkg;

  typedef enum logic [1:0] {
    FUNC_QUERY  = 2'd0,
    FUNC_FAIL   = 2'd1,
    FUNC_CLEAN  = 2'd2,
    FUNC_DELETE = 2'd3
  } func_e;

  localparam int unsigned FAILURE_SLOTS_DEF = 16;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned SPAN_W     = 16;
  localparam int unsigned LIMIT_W    = 5;
  localparam int unsigned STORED_W   = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETENTION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_THIRD     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LONGEST   = 3'd6;

  localparam logic [SPAN_W-1:0]  WINDOW_DEF    = 16'd360;
  localparam logic [SPAN_W-1:0]  RETENTION_DEF = 16'd1200;
  localparam logic [LIMIT_W-1:0] LIMIT_DEF     = 5'd2;
  localparam logic [SPAN_W-1:0]  FIRST_DEF     = 16'd60;
  localparam logic [SPAN_W-1:0]  SECOND_DEF    = 16'd180;
  localparam logic [SPAN_W-1:0]  THIRD_DEF     = 16'd300;
  localparam logic [SPAN_W-1:0]  LONGEST_DEF   = 16'd600;

  typedef struct packed {
    logic              clean;
    logic [TIME_W-1:0] thr;
    logic              thr_neg;
    logic [TIME_W-1:0] last_lock;
  } cmp_cfg_t;

endpackage

// ----- src/fblb_if.sv -----
interface fblb_req_if;
  logic                          valid;
  logic                          ready;
  fblb_pkg::func_e               func;
  logic [fblb_pkg::TIME_W-1:0]   now_time;
  logic                          exempt;

  modport source (output valid, func, now_time, exempt, input ready);
  modport sink (input valid, func, now_time, exempt, output ready);
endinterface

interface fblb_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          frozen;
  logic                          froze_now;
  logic [fblb_pkg::TIME_W-1:0]   lock_start;
  logic [fblb_pkg::TIME_W-1:0]   lock_end;
  logic [fblb_pkg::STORED_W-1:0] stored_failures;

  modport source (output valid, frozen, froze_now, lock_start, lock_end, stored_failures,
                  input ready);
  modport sink (input valid, frozen, froze_now, lock_start, lock_end, stored_failures,
                output ready);
endinterface

// ----- src/fblb_ram.sv -----
module fblb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/fblb_cmp.sv -----
module fblb_cmp (
  input  fblb_pkg::cmp_cfg_t          cfg_i,
  input  logic [fblb_pkg::TIME_W-1:0] entry_i,
  output logic                        hit_o
);

  logic counted;
  logic aged;

  // counted: inside the window and newer than the last lock
  assign counted = (cfg_i.thr_neg || (entry_i > cfg_i.thr)) && (entry_i > cfg_i.last_lock);
  // aged: older than the retention bound
  assign aged    = !cfg_i.thr_neg && (entry_i < cfg_i.thr);
  assign hit_o   = cfg_i.clean ? aged : counted;

endmodule

// ----- src/failed_bind_lockout_backoff.sv -----
// query, delete and exempt items present their result in the cycle after the transfer
// failure items pass ST_SCAN, ST_PUSH and ST_RESP, clean items ST_SCAN and ST_RESP
// the ring is walked one entry per cycle through the single read port of the ring memory
// one item at a time: the next transfer is taken the cycle after the result is taken
// reset: async active low, clears counts, lock state and sets registers to defaults
// ring contents are undefined after reset and only entries below the count are read
module failed_bind_lockout_backoff #(
  parameter int unsigned FAILURE_SLOTS = fblb_pkg::FAILURE_SLOTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fblb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fblb_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  fblb_req_if.sink                          req_i,
  fblb_rsp_if.source                        rsp_o
);

  localparam int unsigned IW = $clog2(FAILURE_SLOTS);
  localparam int unsigned CW = $clog2(FAILURE_SLOTS + 1);
  localparam int unsigned SW = IW + 1;
  localparam int unsigned LW = (CW > fblb_pkg::LIMIT_W) ? CW : fblb_pkg::LIMIT_W;
  localparam int unsigned TW = fblb_pkg::TIME_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUSH,
    ST_RESP
  } state_e;

  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                            input logic [SW-1:0] ofs);
    logic [SW-1:0] sum;
    sum = SW'(base) + ofs;
    if (sum >= SW'(FAILURE_SLOTS)) begin
      sum = sum - SW'(FAILURE_SLOTS);
    end
    return sum[IW-1:0];
  endfunction

  state_e state_q;

  logic [fblb_pkg::SPAN_W-1:0]  window_q;
  logic [fblb_pkg::SPAN_W-1:0]  retention_q;
  logic [fblb_pkg::LIMIT_W-1:0] limit_q;
  logic [fblb_pkg::SPAN_W-1:0]  first_q;
  logic [fblb_pkg::SPAN_W-1:0]  second_q;
  logic [fblb_pkg::SPAN_W-1:0]  third_q;
  logic [fblb_pkg::SPAN_W-1:0]  longest_q;

  logic [CW-1:0] count_q;
  logic [IW-1:0] oldest_q;
  logic [TW-1:0] last_lock_q;
  logic [TW-1:0] lock_begin_q;
  logic [TW-1:0] lock_finish_q;

  fblb_pkg::func_e func_q;
  logic [TW-1:0]   now_q;
  logic [TW-1:0]   thr_q;
  logic            thr_neg_q;
  logic [TW-1:0]   diff_q;
  logic [CW-1:0]   rd_k_q;
  logic [CW-1:0]   wr_n_q;
  logic            pend_q;
  logic [CW-1:0]   counted_q;
  logic            any_old_q;
  logic            frozen_q;
  logic            froze_q;

  logic [fblb_pkg::SPAN_W-1:0] span;
  logic [TW:0]                 thr_sum;
  logic [IW-1:0]               rd_addr;
  logic [SW-1:0]               wr_ofs;
  logic [IW-1:0]               wr_addr;
  logic                        ram_we;
  logic [TW-1:0]               ram_wdata;
  logic [TW-1:0]               ram_rdata;
  fblb_pkg::cmp_cfg_t          cmp_cfg;
  logic                        hit;
  logic                        trigger;
  logic [fblb_pkg::SPAN_W-1:0] next_len;
  logic [TW:0]                 end_sum;
  logic                        scan_done;

  assign span    = (req_i.func == fblb_pkg::FUNC_CLEAN) ? retention_q : window_q;
  assign thr_sum = {1'b0, req_i.now_time} - (TW + 1)'(span);

  assign rd_addr   = slot_of(oldest_q, SW'(rd_k_q));
  assign wr_ofs    = (state_q == ST_PUSH) ? SW'(count_q) : SW'(wr_n_q);
  assign wr_addr   = slot_of(oldest_q, wr_ofs);
  assign ram_we    = (state_q == ST_PUSH) ||
                     ((state_q == ST_SCAN) && pend_q && (func_q == fblb_pkg::FUNC_CLEAN) && !hit);
  assign ram_wdata = (state_q == ST_PUSH) ? now_q : ram_rdata;
  assign scan_done = (rd_k_q == count_q) && !pend_q;

  assign cmp_cfg.clean     = (func_q == fblb_pkg::FUNC_CLEAN);
  assign cmp_cfg.thr       = thr_q;
  assign cmp_cfg.thr_neg   = thr_neg_q;
  assign cmp_cfg.last_lock = last_lock_q;

  always_comb begin
    if (diff_q == '0) begin
      next_len = first_q;
    end else if (diff_q == TW'(first_q)) begin
      next_len = second_q;
    end else if (diff_q == TW'(second_q)) begin
      next_len = third_q;
    end else begin
      next_len = longest_q;
    end
  end

  assign trigger = LW'(counted_q) >= LW'(limit_q);
  assign end_sum = {1'b0, now_q} + (TW + 1)'(next_len);

  fblb_ram #(
    .WIDTH (TW),
    .DEPTH (FAILURE_SLOTS)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  fblb_cmp u_cmp (
    .cfg_i   (cmp_cfg),
    .entry_i (ram_rdata),
    .hit_o   (hit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      window_q      <= fblb_pkg::WINDOW_DEF;
      retention_q   <= fblb_pkg::RETENTION_DEF;
      limit_q       <= fblb_pkg::LIMIT_DEF;
      first_q       <= fblb_pkg::FIRST_DEF;
      second_q      <= fblb_pkg::SECOND_DEF;
      third_q       <= fblb_pkg::THIRD_DEF;
      longest_q     <= fblb_pkg::LONGEST_DEF;
      count_q       <= '0;
      oldest_q      <= '0;
      last_lock_q   <= '0;
      lock_begin_q  <= '0;
      lock_finish_q <= '0;
      func_q        <= fblb_pkg::FUNC_QUERY;
      now_q         <= '0;
      thr_q         <= '0;
      thr_neg_q     <= 1'b0;
      diff_q        <= '0;
      rd_k_q        <= '0;
      wr_n_q        <= '0;
      pend_q        <= 1'b0;
      counted_q     <= '0;
      any_old_q     <= 1'b0;
      frozen_q      <= 1'b0;
      froze_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          fblb_pkg::CFG_WINDOW:    window_q    <= cfg_wdata_i;
          fblb_pkg::CFG_RETENTION: retention_q <= cfg_wdata_i;
          fblb_pkg::CFG_LIMIT:     limit_q     <= cfg_wdata_i[fblb_pkg::LIMIT_W-1:0];
          fblb_pkg::CFG_FIRST:     first_q     <= cfg_wdata_i;
          fblb_pkg::CFG_SECOND:    second_q    <= cfg_wdata_i;
          fblb_pkg::CFG_THIRD:     third_q     <= cfg_wdata_i;
          fblb_pkg::CFG_LONGEST:   longest_q   <= cfg_wdata_i;
          default: ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            func_q    <= req_i.func;
            now_q     <= req_i.now_time;
            thr_q     <= thr_sum[TW-1:0];
            thr_neg_q <= thr_sum[TW];
            diff_q    <= lock_finish_q - lock_begin_q;
            rd_k_q    <= '0;
            wr_n_q    <= '0;
            pend_q    <= 1'b0;
            counted_q <= '0;
            any_old_q <= 1'b0;
            frozen_q  <= 1'b0;
            froze_q   <= 1'b0;
            if (req_i.exempt) begin
              state_q <= ST_RESP;
            end else begin
              unique case (req_i.func)
                fblb_pkg::FUNC_QUERY: begin
                  frozen_q <= (count_q != '0) && (req_i.now_time <= lock_finish_q);
                  state_q  <= ST_RESP;
                end
                fblb_pkg::FUNC_FAIL, fblb_pkg::FUNC_CLEAN: begin
                  state_q <= ST_SCAN;
                end
                fblb_pkg::FUNC_DELETE: begin
                  count_q       <= '0;
                  oldest_q      <= '0;
                  last_lock_q   <= '0;
                  lock_begin_q  <= '0;
                  lock_finish_q <= '0;
                  state_q       <= ST_RESP;
                end
              endcase
            end
          end
        end
        ST_SCAN: begin
          if (rd_k_q != count_q) begin
            rd_k_q <= rd_k_q + 1'b1;
            pend_q <= 1'b1;
          end else begin
            pend_q <= 1'b0;
          end
          if (pend_q) begin
            if (func_q == fblb_pkg::FUNC_CLEAN) begin
              if (hit) begin
                any_old_q <= 1'b1;
              end else begin
                wr_n_q <= wr_n_q + 1'b1;
              end
            end else if (hit) begin
              counted_q <= counted_q + 1'b1;
            end
          end
          if (scan_done) begin
            if (func_q == fblb_pkg::FUNC_CLEAN) begin
              count_q <= wr_n_q;
              if (any_old_q && !thr_neg_q && (last_lock_q < thr_q)) begin
                last_lock_q <= '0;
              end
              if (!((lock_begin_q == '0) && (lock_finish_q == '0)) && !thr_neg_q &&
                  (lock_begin_q < thr_q)) begin
                lock_begin_q  <= '0;
                lock_finish_q <= '0;
              end
              state_q <= ST_RESP;
            end else begin
              state_q <= ST_PUSH;
            end
          end
        end
        ST_PUSH: begin
          if (count_q < CW'(FAILURE_SLOTS)) begin
            count_q <= count_q + 1'b1;
          end else begin
            oldest_q <= slot_of(oldest_q, SW'(1));
          end
          if (trigger) begin
            froze_q       <= 1'b1;
            last_lock_q   <= now_q;
            lock_begin_q  <= now_q;
            lock_finish_q <= end_sum[TW] ? '1 : end_sum[TW-1:0];
          end
          state_q <= ST_RESP;
        end
        ST_RESP: begin
          if (rsp_o.ready) begin
            state_q <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign req_i.ready           = (state_q == ST_IDLE);
  assign rsp_o.valid           = (state_q == ST_RESP);
  assign rsp_o.frozen          = frozen_q;
  assign rsp_o.froze_now       = froze_q;
  assign rsp_o.lock_start      = lock_begin_q;
  assign rsp_o.lock_end        = lock_finish_q;
  assign rsp_o.stored_failures = fblb_pkg::STORED_W'(count_q);

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(FAILURE_SLOTS))
    else $error("failure count above ring depth");

  a_lock_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lock_finish_q >= lock_begin_q)
    else $error("lock end before lock start");

  a_exempt_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready && req_i.exempt |=> rsp_o.valid)
    else $error("exempt transfer did not answer at once");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.ready && rsp_o.valid))
    else $error("new transfer taken while result pending");
`endif

endmodule

// ----- dv/tb_failed_bind_lockout_backoff.sv -----
module tb_failed_bind_lockout_backoff;

  localparam int unsigned SLOTS  = fblb_pkg::FAILURE_SLOTS_DEF;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam logic [fblb_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef struct packed {
    logic                          frozen;
    logic                          froze_now;
    logic [fblb_pkg::TIME_W-1:0]   lock_start;
    logic [fblb_pkg::TIME_W-1:0]   lock_end;
    logic [fblb_pkg::STORED_W-1:0] stored;
  } outcome_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [fblb_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [fblb_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  fblb_req_if req_bus ();
  fblb_rsp_if rsp_bus ();

  failed_bind_lockout_backoff DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  // lockout state as the block should hold it
  logic [fblb_pkg::TIME_W-1:0]  ring_q [SLOTS];
  int unsigned                  ring_cnt;
  int unsigned                  ring_head;
  logic [fblb_pkg::TIME_W-1:0]  last_lock;
  logic [fblb_pkg::TIME_W-1:0]  lock_from;
  logic [fblb_pkg::TIME_W-1:0]  lock_to;
  logic [fblb_pkg::SPAN_W-1:0]  win, keep, len_first, len_second, len_third, len_longest;
  logic [fblb_pkg::LIMIT_W-1:0] lim_cfg;

  outcome_t                    pending_outcomes [$];
  logic [fblb_pkg::TIME_W-1:0] wall;
  bit                          steady = 1'b0;
  int                          rsp_hold = 0;
  int                          mismatches = 0;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic int next_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic void tick(int unsigned d);
    logic [63:0] t;
    t = {32'd0, wall} + d;
    wall = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
  endfunction

  function automatic outcome_t lockout_outcome(fblb_pkg::func_e f,
                                               logic [fblb_pkg::TIME_W-1:0] now, logic ex);
    outcome_t                    o;
    int unsigned                 counted;
    int unsigned                 n;
    logic [fblb_pkg::TIME_W-1:0] v;
    logic [fblb_pkg::TIME_W-1:0] span;
    logic [63:0]                 finish_at;
    logic [fblb_pkg::TIME_W-1:0] kept [SLOTS];
    bit                          any_old;
    o = '0;
    counted = 0;
    n = 0;
    any_old = 1'b0;
    if (!ex) begin
      case (f)
        fblb_pkg::FUNC_QUERY: o.frozen = (ring_cnt != 0) && (now <= lock_to);
        fblb_pkg::FUNC_FAIL: begin
          for (int k = 0; k < ring_cnt; k++) begin
            v = ring_q[SLOT_W'((ring_head + k) % SLOTS)];
            if (({32'd0, v} + win > {32'd0, now}) && (v > last_lock)) counted++;
          end
          if (ring_cnt < SLOTS) begin
            ring_q[SLOT_W'((ring_head + ring_cnt) % SLOTS)] = now;
            ring_cnt++;
          end else begin
            ring_q[SLOT_W'(ring_head)] = now;
            ring_head = (ring_head + 1) % SLOTS;
          end
          if (counted >= lim_cfg) begin
            span = lock_to - lock_from;
            if (span == 0) span = len_first;
            else if (span == len_first) span = len_second;
            else if (span == len_second) span = len_third;
            else span = len_longest;
            finish_at = {32'd0, now} + span;
            last_lock = now;
            lock_from = now;
            lock_to = (finish_at > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : finish_at[31:0];
            o.froze_now = 1'b1;
          end
        end
        fblb_pkg::FUNC_CLEAN: begin
          for (int k = 0; k < ring_cnt; k++) begin
            if ({32'd0, ring_q[SLOT_W'((ring_head + k) % SLOTS)]} + keep < {32'd0, now})
              any_old = 1'b1;
          end
          if (any_old) begin
            for (int k = 0; k < ring_cnt; k++) begin
              v = ring_q[SLOT_W'((ring_head + k) % SLOTS)];
              if (!({32'd0, v} + keep < {32'd0, now})) begin
                kept[SLOT_W'(n)] = v;
                n++;
              end
            end
            for (int k = 0; k < n; k++) ring_q[SLOT_W'(k)] = kept[SLOT_W'(k)];
            ring_cnt = n;
            ring_head = 0;
            if ({32'd0, last_lock} + keep < {32'd0, now}) last_lock = '0;
          end
          if ((lock_from != 0 || lock_to != 0) && ({32'd0, lock_from} + keep < {32'd0, now})) begin
            lock_from = '0;
            lock_to = '0;
          end
        end
        fblb_pkg::FUNC_DELETE: begin
          ring_cnt = 0;
          ring_head = 0;
          last_lock = '0;
          lock_from = '0;
          lock_to = '0;
        end
      endcase
    end
    o.lock_start = lock_from;
    o.lock_end = lock_to;
    o.stored = ring_cnt[fblb_pkg::STORED_W-1:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < 40) $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    mismatches++;
  endtask

  task automatic send_item(fblb_pkg::func_e f, logic [fblb_pkg::TIME_W-1:0] at, logic ex);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid    <= 1'b1;
    req_bus.func     <= f;
    req_bus.now_time <= at;
    req_bus.exempt   <= ex;
    do begin
      @(posedge clk_i);
    end while (req_bus.ready !== 1'b1);
    pending_outcomes.insert(pending_outcomes.size(), lockout_outcome(f, at, ex));
  endtask

  task automatic settle();
    req_bus.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [fblb_pkg::CFG_IDX_W-1:0] idx,
                           logic [fblb_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      fblb_pkg::CFG_WINDOW:    win = val;
      fblb_pkg::CFG_RETENTION: keep = val;
      fblb_pkg::CFG_LIMIT:     lim_cfg = val[fblb_pkg::LIMIT_W-1:0];
      fblb_pkg::CFG_FIRST:     len_first = val;
      fblb_pkg::CFG_SECOND:    len_second = val;
      fblb_pkg::CFG_THIRD:     len_third = val;
      fblb_pkg::CFG_LONGEST:   len_longest = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [fblb_pkg::SPAN_W-1:0] w, logic [fblb_pkg::SPAN_W-1:0] k,
                               logic [fblb_pkg::LIMIT_W-1:0] lim,
                               logic [fblb_pkg::SPAN_W-1:0] f1, logic [fblb_pkg::SPAN_W-1:0] f2,
                               logic [fblb_pkg::SPAN_W-1:0] f3, logic [fblb_pkg::SPAN_W-1:0] f4);
    write_reg(fblb_pkg::CFG_WINDOW, w);
    write_reg(fblb_pkg::CFG_RETENTION, k);
    write_reg(fblb_pkg::CFG_LIMIT, {11'd0, lim});
    write_reg(fblb_pkg::CFG_FIRST, f1);
    write_reg(fblb_pkg::CFG_SECOND, f2);
    write_reg(fblb_pkg::CFG_THIRD, f3);
    write_reg(fblb_pkg::CFG_LONGEST, f4);
  endtask

  // times near zero, lock edges, exempt items, delete
  task automatic check_early_times();
    send_item(fblb_pkg::FUNC_QUERY, 32'd0, 1'b0);
    send_item(fblb_pkg::FUNC_FAIL, 32'd0, 1'b0);
    send_item(fblb_pkg::FUNC_FAIL, 32'd5, 1'b0);
    send_item(fblb_pkg::FUNC_CLEAN, 32'd6, 1'b0);
    send_item(fblb_pkg::FUNC_FAIL, 32'd6, 1'b0);
    send_item(fblb_pkg::FUNC_FAIL, 32'd7, 1'b0);
    send_item(fblb_pkg::FUNC_QUERY, 32'd7, 1'b0);
    send_item(fblb_pkg::FUNC_QUERY, 32'd67, 1'b0);
    send_item(fblb_pkg::FUNC_QUERY, 32'd68, 1'b0);
    send_item(fblb_pkg::FUNC_FAIL, 32'd68, 1'b1);
    send_item(fblb_pkg::FUNC_DELETE, 32'd68, 1'b1);
    send_item(fblb_pkg::FUNC_DELETE, 32'd69, 1'b0);
    wall = 32'd69;
  endtask

  // escalating lengths and coinciding lengths
  task automatic check_backoff_sequence();
    settle();
    load_settings(fblb_pkg::WINDOW_DEF, fblb_pkg::RETENTION_DEF, 5'd0, fblb_pkg::FIRST_DEF,
                  fblb_pkg::SECOND_DEF, fblb_pkg::THIRD_DEF, fblb_pkg::LONGEST_DEF);
    repeat (5) begin
      tick(1);
      send_item(fblb_pkg::FUNC_FAIL, wall, 1'b0);
    end
    settle();
    load_settings(fblb_pkg::WINDOW_DEF, fblb_pkg::RETENTION_DEF, 5'd0, 16'd0, 16'd77,
                  fblb_pkg::THIRD_DEF, fblb_pkg::LONGEST_DEF);
    send_item(fblb_pkg::FUNC_DELETE, wall, 1'b0);
    repeat (2) begin
      tick(1);
      send_item(fblb_pkg::FUNC_FAIL, wall, 1'b0);
    end
    settle();
    load_settings(fblb_pkg::WINDOW_DEF, fblb_pkg::RETENTION_DEF, 5'd0, 16'd40, 16'd40, 16'd40,
                  fblb_pkg::LONGEST_DEF);
    send_item(fblb_pkg::FUNC_DELETE, wall, 1'b0);
    repeat (2) begin
      tick(1);
      send_item(fblb_pkg::FUNC_FAIL, wall, 1'b0);
    end
  endtask

  // writes to an unused index and upper data bits of the limit
  task automatic check_bad_index();
    settle();
    write_reg(CFG_SPARE, 16'hFFFF);
    write_reg(fblb_pkg::CFG_LIMIT, 16'hFFE3);
    repeat (4) begin
      tick(2);
      send_item(fblb_pkg::FUNC_FAIL, wall, 1'b0);
    end
  endtask

  task automatic check_backpressure();
    settle();
    rsp_hold = 300;
    repeat (8) begin
      tick($urandom_range(0, 2));
      send_item(fblb_pkg::FUNC_FAIL, wall, 1'b0);
    end
    settle();
    repeat (4) begin
      tick(1);
      send_item(fblb_pkg::func_e'($urandom_range(0, 2)), wall, 1'b0);
    end
  endtask

  task automatic check_random_traffic();
    int              r;
    int unsigned     dt;
    fblb_pkg::func_e f;
    logic [15:0]     f1, f2, f3;
    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: load_settings(fblb_pkg::WINDOW_DEF, fblb_pkg::RETENTION_DEF, fblb_pkg::LIMIT_DEF,
                         fblb_pkg::FIRST_DEF, fblb_pkg::SECOND_DEF, fblb_pkg::THIRD_DEF,
                         fblb_pkg::LONGEST_DEF);
        1: load_settings(16'($urandom_range(1, 64)), 16'($urandom_range(1, 400)),
                         5'($urandom_range(1, 3)),
                         16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
                         16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)));
        2: load_settings(16'hFFFF, 16'hFFFF, 5'd16, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
        3: load_settings(16'd1, 16'd1, 5'd1, 16'd0, 16'd0, 16'd0, 16'd0);
        4: begin
          f1 = 16'($urandom_range(0, 300));
          f2 = $urandom_range(0, 1) ? f1 : 16'($urandom_range(0, 300));
          f3 = $urandom_range(0, 1) ? f2 : 16'($urandom_range(0, 65535));
          load_settings(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                        5'($urandom_range(0, 17)), f1, f2, f3, 16'($urandom_range(0, 65535)));
        end
        default: load_settings(16'($urandom_range(100, 2000)), 16'($urandom_range(200, 5000)),
                               5'($urandom_range(0, 5)), 16'($urandom_range(1, 100)),
                               16'($urandom_range(1, 100)), 16'($urandom_range(1, 100)),
                               16'($urandom_range(1, 100)));
      endcase
      steady = (p == 2);
      for (int i = 0; i < 250; i++) begin
        r = $urandom_range(0, 99);
        if (r < 50) f = fblb_pkg::FUNC_FAIL;
        else if (r < 78) f = fblb_pkg::FUNC_QUERY;
        else if (r < 95) f = fblb_pkg::FUNC_CLEAN;
        else f = fblb_pkg::FUNC_DELETE;
        r = $urandom_range(0, 99);
        if (r < 55) dt = $urandom_range(0, 3);
        else if (r < 85) dt = $urandom_range(0, win);
        else if (r < 97) dt = $urandom_range(0, 32'(keep) + 32'(keep) / 2);
        else dt = $urandom_range(0, 1 << 22);
        tick(dt);
        send_item(f, wall, $urandom_range(0, 15) == 0);
      end
      steady = 1'b0;
    end
  endtask

  // lock end at the top of the time range
  task automatic check_saturation();
    settle();
    load_settings(16'hFFFF, 16'd1, 5'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1234);
    wall = 32'hFFFF_8000 + $urandom_range(0, 255);
    send_item(fblb_pkg::FUNC_FAIL, wall, 1'b0);
    tick(5);
    send_item(fblb_pkg::FUNC_FAIL, wall, 1'b0);
    wall = 32'hFFFF_FFFF;
    send_item(fblb_pkg::FUNC_QUERY, wall, 1'b0);
    send_item(fblb_pkg::FUNC_CLEAN, wall, 1'b0);
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_hold > 0) begin
        rsp_bus.ready <= 1'b0;
        rsp_hold--;
      end else if (stall_left > 0) begin
        rsp_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_bus.ready <= 1'b1;
        stall_left = next_gap();
      end
    end
  end

  always @(posedge clk_i) begin : check_rsp
    outcome_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result with nothing pending", 32'd0, 32'd0);
      end else begin
        want = pending_outcomes.pop_front();
        if (rsp_bus.frozen !== want.frozen)
          report_mismatch("frozen", 32'(rsp_bus.frozen), 32'(want.frozen));
        if (rsp_bus.froze_now !== want.froze_now)
          report_mismatch("froze_now", 32'(rsp_bus.froze_now), 32'(want.froze_now));
        if (rsp_bus.lock_start !== want.lock_start)
          report_mismatch("lock_start", rsp_bus.lock_start, want.lock_start);
        if (rsp_bus.lock_end !== want.lock_end)
          report_mismatch("lock_end", rsp_bus.lock_end, want.lock_end);
        if (rsp_bus.stored_failures !== want.stored)
          report_mismatch("stored_failures", 32'(rsp_bus.stored_failures), 32'(want.stored));
      end
    end
  end

  initial begin
    int guard;
    guard = 0;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= fblb_pkg::CFG_WINDOW;
    cfg_wdata_i      <= '0;
    req_bus.valid    <= 1'b0;
    req_bus.func     <= fblb_pkg::FUNC_QUERY;
    req_bus.now_time <= '0;
    req_bus.exempt   <= 1'b0;
    win         = fblb_pkg::WINDOW_DEF;
    keep        = fblb_pkg::RETENTION_DEF;
    lim_cfg     = fblb_pkg::LIMIT_DEF;
    len_first   = fblb_pkg::FIRST_DEF;
    len_second  = fblb_pkg::SECOND_DEF;
    len_third   = fblb_pkg::THIRD_DEF;
    len_longest = fblb_pkg::LONGEST_DEF;
    ring_cnt    = 0;
    ring_head   = 0;
    last_lock   = '0;
    lock_from   = '0;
    lock_to     = '0;
    wall        = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_early_times();
    check_backoff_sequence();
    check_bad_index();
    check_backpressure();
    check_random_traffic();
    check_saturation();
    req_bus.valid <= 1'b0;
    while (pending_outcomes.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending_outcomes.size() != 0)
      report_mismatch("results never arrived", pending_outcomes.size(), 32'd0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
